### src/gbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the 5x5 RGB Gaussian blur
// Types for the pixel window, the lane inputs, the register indexes and the
// mapping from a window position to its weight class.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int NCLS = 6;
	localparam int CSW  = 11;
	localparam int WTW  = 16;
	localparam int PIXW = 24;

	typedef logic [4:0][4:0][PIXW-1:0] gbr_win_t;
	typedef logic [4:0][4:0][7:0] gbr_chwin_t;
	typedef logic [NCLS-1:0][WTW-1:0] gbr_wts_t;

	typedef struct packed {
		logic [4:0] row_ok;
		logic [4:0] col_ok;
	} gbr_mask_t;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_W_CENTER,
		REG_W_DIST1,
		REG_W_DIST2,
		REG_W_DIST4,
		REG_W_DIST5,
		REG_W_DIST8
	} gbr_reg_t;

	function automatic logic [2:0] weight_class(input int i, input int j);
		int d;
		logic [2:0] c;
		d = (i - 2) * (i - 2) + (j - 2) * (j - 2);
		case (d)
			0: c = 3'd0;
			1: c = 3'd1;
			2: c = 3'd2;
			4: c = 3'd3;
			5: c = 3'd4;
			default: c = 3'd5;
		endcase
		return c;
	endfunction

endpackage

### src/gbr_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_line_buf: row memory and 5x5 pixel window
// Keeps the four previous rows of each column in one memory word and shifts
// a new column into the window for every transfer that advances the stream.
// ----------------------------------------------------------------------------
module gbr_line_buf #(
	parameter int MAX_WIDTH = gbr_pkg::DEF_MAX_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_act,
	input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
	input  logic [gbr_pkg::PIXW-1:0] in_pix,
	output gbr_pkg::gbr_win_t win
);
	import gbr_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	typedef logic [3:0][PIXW-1:0] stack_t;

	stack_t mem [MAX_WIDTH];
	stack_t rdata_s1;
	stack_t byp_s1;
	stack_t stack;
	stack_t new_word;
	logic hit_s1;
	logic v1_s1;
	logic [AW-1:0] col_s1;
	logic [PIXW-1:0] pix_s1;
	gbr_win_t win_q;
	logic [4:0][PIXW-1:0] col_vec;

	always_comb begin
		stack = hit_s1 ? byp_s1 : rdata_s1;
		new_word = {stack[2:0], pix_s1};
		for (int i = 0; i < 4; i++) begin
			col_vec[i] = stack[3-i];
		end
		col_vec[4] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1 <= mem[in_col];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v1_s1) begin
			mem[col_s1] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_act;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= v1_s1 && (col_s1 == in_col);
			byp_s1 <= new_word;
			col_s1 <= in_col;
			pix_s1 <= in_pix;
			if (v1_s1) begin
				for (int i = 0; i < 5; i++) begin
					for (int j = 0; j < 4; j++) begin
						win_q[i][j] <= win_q[i][j+1];
					end
					win_q[i][4] <= col_vec[i];
				end
			end
		end
	end

	assign win = win_q;

endmodule

### src/gbr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_lane: weighted 5x5 sum of one color channel
// Adds the in-frame pixels of each weight class, multiplies the six class
// sums by their weights, then adds, floors and saturates the result.
// ----------------------------------------------------------------------------
module gbr_lane (
	input  logic clk,
	input  logic en,
	input  gbr_pkg::gbr_chwin_t win,
	input  gbr_pkg::gbr_mask_t mask,
	input  gbr_pkg::gbr_wts_t wts,
	output logic [7:0] res
);
	import gbr_pkg::*;

	localparam int PW = CSW + WTW;
	localparam int SW = PW + 3;

	logic [CSW-1:0] csum [NCLS];
	logic [CSW-1:0] csum_s3 [NCLS];
	logic [PW-1:0] prod_s4 [NCLS];
	logic [SW-1:0] total;

	always_comb begin
		for (int k = 0; k < NCLS; k++) begin
			csum[k] = '0;
		end
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				if (mask.row_ok[i] && mask.col_ok[j]) begin
					csum[weight_class(i, j)] = csum[weight_class(i, j)] + CSW'(win[i][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NCLS; k++) begin
				csum_s3[k] <= csum[k];
				prod_s4[k] <= csum_s3[k] * wts[k];
			end
		end
	end

	always_comb begin
		total = '0;
		for (int k = 0; k < NCLS; k++) begin
			total = total + SW'(prod_s4[k]);
		end
		res = (total[SW-1:16] > (SW-16)'(255)) ? 8'hff : total[23:16];
	end

endmodule

### src/gaussian_blur_5x5_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb: 5x5 Gaussian blur of an RGB raster stream
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid tready tdata tuser    pixel or flush
// m_axis    out  tvalid tready tdata tlast    filtered pixel, end of frame
// cfg       in   cfg_we cfg_index cfg_data    geometry and weights
// One pixel per clock while the output is not stalled and the input is not held
// off; an accepted transfer passes the s1 to s4 registers into the output
// register, and the result of pixel k leaves with transfer k+2*width+2. The row
// memory has one write and one read port per cycle. After a geometry write the
// input is held off until busy_q clears. A stall on the output stops the whole pipeline; reset clears all counters.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb #(
	parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gbr_pkg::DEF_MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	input  logic s_axis_tuser,          // req_type
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import gbr_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);

	logic [10:0] width_q;
	logic [12:0] height_q;
	gbr_wts_t wts_q;
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [WW+HW-1:0] prod;
	logic [TW-1:0] total_q, lat_q, end_q;
	logic [1:0] busy_q;
	logic geo_wr;

	logic [TW-1:0] t_q;
	logic [AW-1:0] in_col_q;
	logic [WW-1:0] oc_q;
	logic [HW-1:0] orow_q;

	logic en, acc, act, emit, last;
	gbr_mask_t mask;

	logic emit_s1, last_s1, last_s2, last_s3, last_s4;
	logic v1_s1, v2_s2, v3_s3, v4_s4, ov_q;
	gbr_mask_t mask_s1, mask_s2;
	logic [23:0] data_q;
	logic last_q;

	gbr_win_t win;
	logic [2:0][7:0] lane_res;

	assign geo_wr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 13'd1024;
			wts_q <= {{(NCLS-1){16'h0000}}, 16'hffff};
		end else if (cfg_we) begin
			unique case (gbr_reg_t'(cfg_index))
				REG_WIDTH: width_q <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_W_CENTER: wts_q[0] <= cfg_data;
				REG_W_DIST1: wts_q[1] <= cfg_data;
				REG_W_DIST2: wts_q[2] <= cfg_data;
				REG_W_DIST4: wts_q[3] <= cfg_data;
				REG_W_DIST5: wts_q[4] <= cfg_data;
				REG_W_DIST8: wts_q[5] <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
		prod = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);
	end

	always_ff @(posedge clk) begin
		total_q <= TW'(prod);
		lat_q <= TW'({eff_w, 1'b0}) + TW'(2);
		end_q <= total_q + lat_q - TW'(1);
	end

	assign en = !ov_q || m_axis_tready;
	assign s_axis_tready = en && (busy_q == 2'b00);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign act = !((t_q < total_q) && s_axis_tuser);
	assign emit = (t_q >= lat_q);
	assign last = (t_q == end_q);

	always_comb begin
		mask.row_ok[0] = (orow_q >= HW'(2));
		mask.row_ok[1] = (orow_q >= HW'(1));
		mask.row_ok[2] = 1'b1;
		mask.row_ok[3] = ((HW+1)'(orow_q) + (HW+1)'(1)) < (HW+1)'(eff_h);
		mask.row_ok[4] = ((HW+1)'(orow_q) + (HW+1)'(2)) < (HW+1)'(eff_h);
		mask.col_ok[0] = (oc_q >= WW'(2));
		mask.col_ok[1] = (oc_q >= WW'(1));
		mask.col_ok[2] = 1'b1;
		mask.col_ok[3] = ((WW+1)'(oc_q) + (WW+1)'(1)) < (WW+1)'(eff_w);
		mask.col_ok[4] = ((WW+1)'(oc_q) + (WW+1)'(2)) < (WW+1)'(eff_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
			t_q <= '0;
			in_col_q <= '0;
			oc_q <= '0;
			orow_q <= '0;
		end else begin
			busy_q <= {busy_q[0], geo_wr};
			if (geo_wr) begin
				t_q <= '0;
				in_col_q <= '0;
				oc_q <= '0;
				orow_q <= '0;
			end else if (acc && act) begin
				if (last) begin
					t_q <= '0;
					in_col_q <= '0;
					oc_q <= '0;
					orow_q <= '0;
				end else begin
					t_q <= t_q + TW'(1);
					if (WW'(in_col_q) + WW'(1) == eff_w) begin
						in_col_q <= '0;
					end else begin
						in_col_q <= in_col_q + AW'(1);
					end
					if (emit) begin
						if (oc_q + WW'(1) == eff_w) begin
							oc_q <= '0;
							orow_q <= orow_q + HW'(1);
						end else begin
							oc_q <= oc_q + WW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v1_s1 <= acc && act;
			v2_s2 <= v1_s1 && emit_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			ov_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emit_s1 <= emit;
			last_s1 <= last;
			mask_s1 <= mask;
			last_s2 <= last_s1;
			mask_s2 <= mask_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_q <= last_s4;
			data_q <= lane_res;
		end
	end

	gbr_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_act(acc && act),
		.in_col(in_col_q),
		.in_pix(s_axis_tdata),
		.win(win)
	);

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		gbr_chwin_t chwin;
		always_comb begin
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 5; j++) begin
					chwin[i][j] = win[i][j][8*ch +: 8];
				end
			end
		end
		gbr_lane u_lane (
			.clk(clk),
			.en(en),
			.win(chwin),
			.mask(mask_s2),
			.wts(wts_q),
			.res(lane_res[ch])
		);
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tlast = last_q;

endmodule
